// File: sv/pfa_pkg.sv
// Package for the page frame allocator: field widths, result kind codes,
// register map and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package pfa_pkg;

  // field widths fixed by the interface
  localparam int CNT_W  = 7;
  localparam int ID_W   = 6;
  localparam int KIND_W = 2;
  localparam int PAGE_W = 6;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVICTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOTHING = 2'd2;

  // operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_EVICT = 1'b1;

  // register map: register index is paddr[2]
  localparam logic REG_PAGES_IN_USE = 1'b0;

  // pool size after reset
  localparam logic [CNT_W-1:0] PAGES_RESET = 7'd64;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic alloc_step;
    logic alloc_finish;
    logic evict_step;
    logic evict_finish;
    logic emit_nothing;
  } pfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic load_nothing;
    logic alloc_done;
    logic evict_last;
    logic evict_end;
  } pfa_stat_t;

endpackage

`default_nettype wire

// File: sv/pfa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/pfa_ctrl.sv
// Allocator sequencer: steps an item through capture, load, frame scan and finish.
// Depends on pfa_pkg.
`default_nettype none

module pfa_ctrl
  import pfa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire pfa_stat_t stat,
  output pfa_cmd_t       cmd,
  output logic           busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_ALLOC,
    S_EVICT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (stat.is_alloc) begin
          state_next = S_ALLOC;
        end else if (stat.load_nothing) begin
          cmd.emit_nothing = 1'b1;
          state_next       = S_IDLE;
        end else begin
          state_next = S_EVICT;
        end
      end
      S_ALLOC: begin
        if (stat.alloc_done) begin
          cmd.alloc_finish = 1'b1;
          state_next       = S_IDLE;
        end else begin
          cmd.alloc_step = 1'b1;
        end
      end
      S_EVICT: begin
        cmd.evict_step = 1'b1;
        if (stat.evict_last || stat.evict_end) begin
          cmd.evict_finish = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

// File: sv/pfa_datapath.sv
// Allocator datapath: frame free map, owner and held-count RAMs, scan counters
// and the registered result beat. Depends on pfa_pkg and pfa_ram.
`default_nettype none

module pfa_datapath
  import pfa_pkg::*;
#(
  parameter int PAGE_FRAMES   = 64,
  parameter int PROCESS_SLOTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_data,
  input  wire logic              operation,
  input  wire logic [ID_W-1:0]   proc_id,
  input  wire logic [CNT_W-1:0]  page_count,
  input  wire pfa_cmd_t          cmd,
  output pfa_stat_t              stat,
  output logic [CNT_W-1:0]       pages_in_use,
  output logic                   valid,
  output logic [KIND_W-1:0]      kind,
  output logic [PAGE_W-1:0]      freed_page,
  output logic [CNT_W-1:0]       granted,
  output logic                   short_of_pages,
  output logic [CNT_W-1:0]       free_count,
  output logic                   last
);

  localparam int FIW = $clog2(PAGE_FRAMES);
  localparam int HD  = (PROCESS_SLOTS < (1 << ID_W)) ? PROCESS_SLOTS : (1 << ID_W);
  localparam int HW  = (HD > 1) ? $clog2(HD) : 1;

  // item registers
  logic             op_r;
  logic [ID_W-1:0]  pid_r;
  logic [CNT_W-1:0] cnt_r;
  logic             slot_r;
  logic [CNT_W-1:0] held_r;
  logic [CNT_W-1:0] need_r;
  logic [CNT_W-1:0] granted_r;
  logic             freed_any;

  // pool state
  logic [CNT_W-1:0]       pool_size;
  logic [CNT_W-1:0]       free_total;
  logic [PAGE_FRAMES-1:0] free_vec;
  logic [HD-1:0]          held_valid;

  // scan counter and check stage of the evict pipeline
  logic [FIW:0]   ridx;
  logic [FIW-1:0] ridx_lo;
  logic           ridx_in_pool;
  logic           chk_valid;
  logic [FIW-1:0] chk_idx;

  // RAM connections
  logic [ID_W-1:0]  owner_q;
  logic             held_we;
  logic [CNT_W-1:0] held_wdata;
  logic [CNT_W-1:0] held_q;
  logic             owner_we;

  // rebuild on reset or pool resize
  logic             rebuild;
  logic [CNT_W-1:0] rebuild_val;
  logic [CNT_W-1:0] pool_sat;

  logic [CNT_W-1:0] held_val;
  logic             alloc_take;
  logic             hit;
  logic             hit_last;

  assign rebuild     = rst || cfg_we;
  assign rebuild_val = rst ? PAGES_RESET : cfg_data;
  assign pool_sat    = (32'(rebuild_val) > 32'(PAGE_FRAMES)) ?
                       CNT_W'(PAGE_FRAMES) : rebuild_val;

  assign ridx_lo      = ridx[FIW-1:0];
  assign ridx_in_pool = (CNT_W'(ridx) < pool_size);

  // held count as seen at load: zero for no slot or a never written slot
  assign held_val = (slot_r && held_valid[pid_r[HW-1:0]]) ? held_q : '0;

  assign alloc_take = cmd.alloc_step && free_vec[ridx_lo];
  assign hit        = cmd.evict_step && chk_valid && !free_vec[chk_idx] &&
                      (owner_q == pid_r);
  assign hit_last   = hit && ((held_r - 7'd1) == cnt_r);

  // status to the sequencer
  always_comb begin
    stat.is_alloc     = (op_r == OP_ALLOC);
    stat.load_nothing = (op_r == OP_EVICT) && (held_val <= cnt_r);
    stat.alloc_done   = (granted_r == need_r) || !ridx_in_pool;
    stat.evict_last   = hit_last;
    stat.evict_end    = !chk_valid && !ridx_in_pool;
  end

  // held count write-back at the end of an item
  assign held_we    = slot_r && (cmd.alloc_finish || cmd.evict_finish);
  assign held_wdata = cmd.alloc_finish ? (held_r + granted_r) :
                      (hit ? (held_r - 7'd1) : held_r);
  assign owner_we   = alloc_take;

  pfa_ram #(
    .WIDTH (ID_W),
    .DEPTH (PAGE_FRAMES)
  ) u_owner_ram (
    .clk   (clk),
    .we    (owner_we),
    .waddr (ridx_lo),
    .wdata (pid_r),
    .raddr (ridx_lo),
    .rdata (owner_q)
  );

  pfa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HD)
  ) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (pid_r[HW-1:0]),
    .wdata (held_wdata),
    .raddr (proc_id[HW-1:0]),
    .rdata (held_q)
  );

  // pool register, free map and held valid bits
  always_ff @(posedge clk) begin
    if (rebuild) begin
      pages_in_use <= rebuild_val;
      pool_size    <= pool_sat;
      free_total   <= pool_sat;
      held_valid   <= '0;
      for (int f = 0; f < PAGE_FRAMES; f++) begin
        free_vec[f] <= (f < 32'(pool_sat));
      end
    end else begin
      if (alloc_take) begin
        free_vec[ridx_lo] <= 1'b0;
        free_total        <= free_total - 7'd1;
      end else if (hit) begin
        free_vec[chk_idx] <= 1'b1;
        free_total        <= free_total + 7'd1;
      end
      if (held_we) begin
        held_valid[pid_r[HW-1:0]] <= 1'b1;
      end
    end
  end

  // item capture, load and scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ridx      <= '0;
      chk_valid <= 1'b0;
      freed_any <= 1'b0;
    end else begin
      if (cmd.capture) begin
        op_r   <= operation;
        pid_r  <= proc_id;
        cnt_r  <= page_count;
        slot_r <= (32'(proc_id) < 32'(PROCESS_SLOTS));
      end
      if (cmd.load) begin
        held_r    <= held_val;
        need_r    <= (slot_r && (cnt_r > held_val)) ? (cnt_r - held_val) : '0;
        granted_r <= '0;
        ridx      <= '0;
        chk_valid <= 1'b0;
        freed_any <= 1'b0;
      end
      if (cmd.alloc_step) begin
        ridx <= ridx + 1'b1;
        if (alloc_take) begin
          granted_r <= granted_r + 7'd1;
        end
      end
      if (cmd.evict_step) begin
        chk_valid <= ridx_in_pool;
        chk_idx   <= ridx_lo;
        if (ridx_in_pool) begin
          ridx <= ridx + 1'b1;
        end
        if (hit) begin
          held_r    <= held_r - 7'd1;
          freed_any <= 1'b1;
        end
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.alloc_finish || cmd.emit_nothing || hit ||
               (cmd.evict_finish && !freed_any);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_finish) begin
      kind           <= KIND_SUMMARY;
      freed_page     <= '0;
      granted        <= granted_r;
      short_of_pages <= (granted_r < need_r);
      free_count     <= free_total;
      last           <= 1'b1;
    end else if (hit) begin
      kind           <= KIND_EVICTED;
      freed_page     <= PAGE_W'(chk_idx);
      granted        <= '0;
      short_of_pages <= 1'b0;
      free_count     <= free_total + 7'd1;
      last           <= hit_last;
    end else begin
      // nothing to evict
      kind           <= KIND_NOTHING;
      freed_page     <= '0;
      granted        <= '0;
      short_of_pages <= 1'b0;
      free_count     <= free_total;
      last           <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: sv/page_frame_allocator_core.sv
// Top level of the lowest-free page frame allocator: APB register decode,
// sequencer and datapath. Depends on pfa_pkg, pfa_ctrl, pfa_datapath, pfa_ram.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------------------
//  item in  | start, busy (taken: !busy)    | operation, proc_id, page_count
//  result   | valid, one cycle per beat     | kind, freed_page, granted,
//           |                               | short_of_pages, free_count, last
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Allocate: after capture and load, frames are scanned from frame 0 until the request
// is met or the pool ends (at most the pool size), one frame a cycle through the free map.
// Evict: frames are scanned up to the last freed frame and its freed-page beat, the
// owner RAM read adding one pipeline stage; a single nothing beat when nothing is evicted.
// Reset or a pool size write rebuilds the pool directly; no clearing pass.
// Results cannot be held off; busy stays high until the last beat is issued.
`default_nettype none

module page_frame_allocator_core
  import pfa_pkg::*;
#(
  parameter int PAGE_FRAMES   = 64,
  parameter int PROCESS_SLOTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  // item in
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              operation,
  input  wire logic [ID_W-1:0]   proc_id,
  input  wire logic [CNT_W-1:0]  page_count,
  // results
  output logic                   valid,
  output logic [KIND_W-1:0]      kind,
  output logic [PAGE_W-1:0]      freed_page,
  output logic [CNT_W-1:0]       granted,
  output logic                   short_of_pages,
  output logic [CNT_W-1:0]       free_count,
  output logic                   last
);

  pfa_cmd_t         cmd;
  pfa_stat_t        stat;
  logic             cfg_we;
  logic [CNT_W-1:0] pages_in_use;

  // register decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PAGES_IN_USE);
  assign prdata = (paddr[2] == REG_PAGES_IN_USE) ? APB_DW'(pages_in_use) : '0;

  pfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start && !busy),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pfa_datapath #(
    .PAGE_FRAMES   (PAGE_FRAMES),
    .PROCESS_SLOTS (PROCESS_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (pwdata[CNT_W-1:0]),
    .operation      (operation),
    .proc_id        (proc_id),
    .page_count     (page_count),
    .cmd            (cmd),
    .stat           (stat),
    .pages_in_use   (pages_in_use),
    .valid          (valid),
    .kind           (kind),
    .freed_page     (freed_page),
    .granted        (granted),
    .short_of_pages (short_of_pages),
    .free_count     (free_count),
    .last           (last)
  );

endmodule

`default_nettype wire

// File: sv/pfa_checker.sv
// Port-level checks for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and page_frame_allocator_core.
`default_nettype none

module pfa_checker
  import pfa_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              valid,
  input wire logic [KIND_W-1:0] kind,
  input wire logic [PAGE_W-1:0] freed_page,
  input wire logic [CNT_W-1:0]  granted,
  input wire logic [CNT_W-1:0]  free_count,
  input wire logic              last
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // more beats follow a non-final beat, so the block must still be busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |-> busy)
    else $error("non-final beat while idle");

  // summary and nothing beats end their item and carry no page
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    (valid && (kind == KIND_SUMMARY || kind == KIND_NOTHING)) |->
      (last && freed_page == '0))
    else $error("summary or nothing beat malformed");

  // only a summary reports granted pages
  a_granted: assert property (@(posedge clk) disable iff (rst)
    (valid && kind != KIND_SUMMARY) |-> (granted == '0))
    else $error("granted set outside a summary");

  // free count never exceeds the frame range
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (free_count <= 7'd64))
    else $error("free count out of range");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);

`default_nettype wire
